/* rtl/daylength_from_day_of_year_macros.svh */
// Assertion macros shared by the day length RTL.
`ifndef DAYLENGTH_FROM_DAY_OF_YEAR_MACROS_SVH
`define DAYLENGTH_FROM_DAY_OF_YEAR_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define DAYL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define DAYL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DAYL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DAYL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/dayl_pkg.sv */
package dayl_pkg;

    // Default CORDIC depth and datapath width of the CORDIC units
    localparam int DAYL_CORDIC_STAGES = 16;
    localparam int CW = 34;

    // Step counts of the modulo, division, square root and normalization pipelines
    localparam int MOD_STEPS = 10;
    localparam int DIV_STEPS = 32;
    localparam int ISQ_STEPS = 32;
    localparam int NORM_STEPS = 6;

    // Q30 constants, then the hour scale and the half and full day in 1/2048 hour
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [31:0] KINV_Q30 = 32'd652032874;
    localparam logic [31:0] SIN235_Q30 = 32'd428153553;
    localparam logic [29:0] HOUR_MUL = 30'd1025347913;
    localparam logic [15:0] HALF_DAY = 16'd24576;
    localparam logic [15:0] FULL_DAY = 16'd49152;

    // Latitude to radians: PI_Q30 = 18000*LAT_Q + LAT_RM
    localparam logic [13:0] LAT_MAX = 14'd9000;
    localparam logic [17:0] LAT_Q = 18'd187403;
    localparam logic [12:0] LAT_RM = 13'd5426;
    localparam logic [13:0] LAT_BIAS = 14'd9000;
    localparam logic [14:0] LAT_DIV = 15'd18000;
    localparam logic [26:0] LAT_RECIP = 27'd122167958;  // floor(2^41/18000)
    localparam int LAT_RSH = 41;

    // Configuration register indexes
    localparam logic CFG_DAYS = 1'b0;
    localparam logic CFG_LAT = 1'b1;

    // atan(2^-i) in Q30
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'h3243F6A8;
            5'd1: v = 32'h1DAC6705;
            5'd2: v = 32'h0FADBAFC;
            5'd3: v = 32'h07F56EA6;
            5'd4: v = 32'h03FEAB76;
            5'd5: v = 32'h01FFD55B;
            5'd6: v = 32'h00FFFAAA;
            5'd7: v = 32'h007FFF55;
            5'd8: v = 32'h003FFFEA;
            5'd9: v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

/* rtl/dayl_cordic.sv */
module dayl_cordic #(
    parameter int STAGES = dayl_pkg::DAYL_CORDIC_STAGES,
    parameter int SW = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vector_mode,
    input  logic                           i_valid,
    input  logic signed [dayl_pkg::CW-1:0] i_x,
    input  logic signed [dayl_pkg::CW-1:0] i_y,
    input  logic signed [dayl_pkg::CW-1:0] i_z,
    input  logic [SW-1:0]                  i_side,
    output logic                           o_valid,
    output logic signed [dayl_pkg::CW-1:0] o_x,
    output logic signed [dayl_pkg::CW-1:0] o_y,
    output logic signed [dayl_pkg::CW-1:0] o_z,
    output logic [SW-1:0]                  o_side
);
    import dayl_pkg::*;

    logic signed [CW-1:0] r_x [STAGES];
    logic signed [CW-1:0] r_y [STAGES];
    logic signed [CW-1:0] r_z [STAGES];
    logic [SW-1:0]        r_s [STAGES];
    logic                 r_v [STAGES];

    // One micro-rotation per stage
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic signed [CW-1:0] x_in, y_in, z_in, xs, ys, at;
        logic [SW-1:0]        s_in;
        logic                 v_in, dir;

        if (k == 0) begin : g_first
            assign x_in = i_x;
            assign y_in = i_y;
            assign z_in = i_z;
            assign s_in = i_side;
            assign v_in = i_valid;
        end else begin : g_next
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
            assign s_in = r_s[k-1];
            assign v_in = r_v[k-1];
        end

        assign xs = x_in >>> k;
        assign ys = y_in >>> k;
        assign at = signed'({{(CW-32){1'b0}}, atan_q30(5'(k))});
        // rotation steers on angle sign, vectoring on y sign
        assign dir = i_vector_mode ? (y_in <= 0) : (z_in >= 0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
            r_x[k] <= dir ? x_in - ys : x_in + ys;
            r_y[k] <= dir ? y_in + xs : y_in - xs;
            r_z[k] <= dir ? z_in - at : z_in + at;
            r_s[k] <= s_in;
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_x = r_x[STAGES-1];
    assign o_y = r_y[STAGES-1];
    assign o_z = r_z[STAGES-1];
    assign o_side = r_s[STAGES-1];

endmodule

/* rtl/dayl_isqrt.sv */
module dayl_isqrt #(
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [63:0]   i_v,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [31:0]   o_root,
    output logic [SW-1:0] o_side
);
    import dayl_pkg::*;

    logic [63:0]   r_rem [ISQ_STEPS];
    logic [63:0]   r_root [ISQ_STEPS];
    logic [SW-1:0] r_s [ISQ_STEPS];
    logic          r_v [ISQ_STEPS];

    // One result bit per stage, trial bit walks down by two
    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
        logic [63:0]   v_in, r_in, b, t;
        logic [SW-1:0] s_in;
        logic          val_in, ge;

        if (k == 0) begin : g_first
            assign v_in = i_v;
            assign r_in = '0;
            assign s_in = i_side;
            assign val_in = i_valid;
        end else begin : g_next
            assign v_in = r_rem[k-1];
            assign r_in = r_root[k-1];
            assign s_in = r_s[k-1];
            assign val_in = r_v[k-1];
        end

        assign b = 64'd1 << (62 - 2 * k);
        assign t = r_in + b;
        assign ge = v_in >= t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= val_in;
            end
            r_rem[k] <= ge ? v_in - t : v_in;
            r_root[k] <= ge ? (r_in >> 1) + b : r_in >> 1;
            r_s[k] <= s_in;
        end
    end

    assign o_valid = r_v[ISQ_STEPS-1];
    assign o_root = r_root[ISQ_STEPS-1][31:0];
    assign o_side = r_s[ISQ_STEPS-1];

endmodule

/* rtl/daylength_from_day_of_year.sv */
// Day length from day of year: fully pipelined, one item per cycle.
// The item path holds the 42 divider steps, two CORDICs and the two 32-step square root
// pipelines. busy stays low: the pipeline never stalls since the receiver cannot hold
// results off. Reset (synchronous, active low) clears valid bits and sets 365 days, latitude 0;
// latitude trig runs free from the registers and settles long before an item needs it.
`include "daylength_from_day_of_year_macros.svh"

module daylength_from_day_of_year #(
    parameter int CORDIC_STAGES = dayl_pkg::DAYL_CORDIC_STAGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [8:0]  i_day_index,
    output logic        o_strobe,
    output logic [15:0] o_daylight_hours,
    output logic        o_polar_clamped,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [14:0] i_cfg_data
);
    import dayl_pkg::*;

    localparam int LATENCY = 124 + 2 * CORDIC_STAGES;

    // Configuration registers
    logic [8:0]         r_days;
    logic signed [14:0] r_lat;
    logic [8:0]         d_eff;

    assign o_cfg_ready = 1'b1;
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_days <= 9'd365;
            r_lat <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DAYS: r_days <= i_cfg_data[8:0];
                CFG_LAT:  r_lat <= signed'(i_cfg_data);
                default:  ;
            endcase
        end
    end

    assign d_eff = (r_days == 9'd0) ? 9'd1 : r_days;

    // ---------------- latitude path, free running ----------------
    logic signed [14:0]   latc;
    logic                 r_lsg1, r_lsg2, r_lsg3, r_lsg4;
    logic [13:0]          r_lm;
    logic [30:0]          r_lmq2, r_lmq3, r_lmq4;
    logic [25:0]          r_ly2, r_ly3, r_ly4;
    logic [52:0]          r_lp;
    logic [11:0]          r_lqe;
    logic [25:0]          r_lt;
    logic [30:0]          lr;
    logic signed [CW-1:0] r_lz;
    logic signed [CW-1:0] lat_x, lat_y;
    logic signed [CW-1:0] r_slat;
    logic [32:0]          r_clat;

    always_comb begin
        latc = r_lat;
        if (r_lat > signed'({1'b0, LAT_MAX})) latc = signed'({1'b0, LAT_MAX});
        if (r_lat < -signed'({1'b0, LAT_MAX})) latc = -signed'({1'b0, LAT_MAX});
    end

    // round(|lat|*PI_Q30/18000) split into an exact and a small remainder part
    assign lr = r_lmq4 + 31'(r_lqe) + 31'((r_ly4 - r_lt) >= 26'(LAT_DIV));

    always_ff @(posedge i_clk) begin
        r_lsg1 <= latc[14];
        r_lm <= latc[14] ? 14'(-latc) : 14'(latc);
        r_lsg2 <= r_lsg1;
        r_lmq2 <= 31'(r_lm) * 31'(LAT_Q);
        r_ly2 <= 26'(r_lm) * 26'(LAT_RM) + 26'(LAT_BIAS);
        r_lsg3 <= r_lsg2;
        r_lmq3 <= r_lmq2;
        r_ly3 <= r_ly2;
        r_lp <= 53'(r_ly2) * 53'(LAT_RECIP);
        r_lsg4 <= r_lsg3;
        r_lmq4 <= r_lmq3;
        r_ly4 <= r_ly3;
        r_lqe <= r_lp[52:LAT_RSH];
        r_lt <= 26'(r_lp[52:LAT_RSH]) * 26'(LAT_DIV);
        r_lz <= r_lsg4 ? -signed'(CW'(lr)) : signed'(CW'(lr));
        r_slat <= lat_y;
        r_clat <= lat_x[CW-1] ? 33'd0 : 33'(lat_x);
    end

    dayl_cordic #(.STAGES(CORDIC_STAGES), .SW(1)) u_lat_rot (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vector_mode (1'b0),
        .i_valid       (1'b1),
        .i_x           (signed'(CW'(KINV_Q30))),
        .i_y           ('0),
        .i_z           (r_lz),
        .i_side        (1'b0),
        .o_valid       (),
        .o_x           (lat_x),
        .o_y           (lat_y),
        .o_z           (),
        .o_side        ()
    );

    // ---------------- day path ----------------
    logic [8:0] r_day;
    logic       r_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else begin
            r_dv <= start && !busy;
        end
        r_day <= i_day_index;
    end

    // (day + 10) mod D, one restoring step per stage
    logic [9:0] r_mrem [MOD_STEPS];
    logic       r_mv [MOD_STEPS];

    for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
        logic [9:0]  rem_in;
        logic [18:0] dsh;
        logic        v_in, ge;

        if (k == 0) begin : g_first
            assign rem_in = 10'(r_day) + 10'd10;
            assign v_in = r_dv;
        end else begin : g_next
            assign rem_in = r_mrem[k-1];
            assign v_in = r_mv[k-1];
        end

        assign dsh = 19'(d_eff) << (MOD_STEPS - 1 - k);
        assign ge = 19'(rem_in) >= dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mv[k] <= 1'b0;
            end else begin
                r_mv[k] <= v_in;
            end
            r_mrem[k] <= ge ? rem_in - dsh[9:0] : rem_in;
        end
    end

    // phase = n * 2^32 / D, one quotient bit per stage
    logic [8:0]  r_qrem [DIV_STEPS];
    logic [31:0] r_quo [DIV_STEPS];
    logic        r_qv [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [8:0]  r_in;
        logic [31:0] q_in;
        logic [9:0]  t;
        logic        v_in, ge;

        if (k == 0) begin : g_first
            assign r_in = r_mrem[MOD_STEPS-1][8:0];
            assign q_in = '0;
            assign v_in = r_mv[MOD_STEPS-1];
        end else begin : g_next
            assign r_in = r_qrem[k-1];
            assign q_in = r_quo[k-1];
            assign v_in = r_qv[k-1];
        end

        assign t = {r_in, 1'b0};
        assign ge = t >= {1'b0, d_eff};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qv[k] <= 1'b0;
            end else begin
                r_qv[k] <= v_in;
            end
            r_qrem[k] <= ge ? 9'(t - {1'b0, d_eff}) : t[8:0];
            r_quo[k] <= {q_in[30:0], ge};
        end
    end

    // fold the phase to a quarter turn, then scale to radians
    logic [31:0] f_in, f1;
    logic        fneg;
    logic [30:0] r_f;
    logic        r_fneg, r_fv;
    logic [62:0] r_zp;
    logic        r_zneg, r_zv;

    assign f_in = r_quo[DIV_STEPS-1];
    assign f1 = f_in[31] ? 32'(33'h1_0000_0000 - {1'b0, f_in}) : f_in;
    assign fneg = f1 > 32'h4000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
            r_zv <= 1'b0;
        end else begin
            r_fv <= r_qv[DIV_STEPS-1];
            r_zv <= r_fv;
        end
        r_f <= fneg ? 31'(32'h8000_0000 - f1) : f1[30:0];
        r_fneg <= fneg;
        r_zp <= 63'(r_f) * 63'(PI_Q30);
        r_zneg <= r_fneg;
    end

    // cosine of the day angle
    logic signed [CW-1:0] day_x;
    logic                 day_v, day_neg;

    dayl_cordic #(.STAGES(CORDIC_STAGES), .SW(1)) u_day_rot (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vector_mode (1'b0),
        .i_valid       (r_zv),
        .i_x           (signed'(CW'(KINV_Q30))),
        .i_y           ('0),
        .i_z           (signed'({2'b00, r_zp[62:31]})),
        .i_side        (r_zneg),
        .o_valid       (day_v),
        .o_x           (day_x),
        .o_y           (),
        .o_z           (),
        .o_side        (day_neg)
    );

    // declination sine and the argument of its cosine
    logic signed [32:0] coef;
    logic signed [63:0] r_sp;
    logic signed [30:0] sdec_c;
    logic signed [30:0] r_sdec1, r_sdec2;
    logic [61:0]        r_sq;
    logic [63:0]        r_isv;
    logic               r_m1v, r_m2v, r_m3v;

    assign coef = day_neg ? signed'({1'b0, SIN235_Q30}) : -signed'({1'b0, SIN235_Q30});
    assign sdec_c = r_sp[60:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1v <= 1'b0;
            r_m2v <= 1'b0;
            r_m3v <= 1'b0;
        end else begin
            r_m1v <= day_v;
            r_m2v <= r_m1v;
            r_m3v <= r_m2v;
        end
        r_sp <= 64'(coef) * 64'(day_x);
        r_sdec1 <= sdec_c;
        r_sq <= 62'(62'(sdec_c) * 62'(sdec_c));
        r_sdec2 <= r_sdec1;
        r_isv <= (64'd1 << 60) - 64'(r_sq);
    end

    logic [31:0]        cdec;
    logic [30:0]        cdec_side;
    logic               cdec_v;

    dayl_isqrt #(.SW(31)) u_cdec_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m3v),
        .i_v     (r_isv),
        .i_side  (r_sdec2),
        .o_valid (cdec_v),
        .o_root  (cdec),
        .o_side  (cdec_side)
    );

    // numerator and denominator of the hour angle cosine
    logic signed [63:0] r_num;
    logic [63:0]        r_den, mag_c;
    logic               r_m4v;
    logic [63:0]        r_mag, r_dn;
    logic               r_pol, r_nneg, r_m5v;

    assign mag_c = r_num[63] ? 64'(-r_num) : 64'(r_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m4v <= 1'b0;
            r_m5v <= 1'b0;
        end else begin
            r_m4v <= cdec_v;
            r_m5v <= r_m4v;
        end
        r_num <= 64'(r_slat) * 64'(signed'(cdec_side));
        r_den <= 64'(r_clat) * 64'(cdec);
        r_mag <= mag_c;
        r_dn <= r_den;
        r_pol <= mag_c > r_den;
        r_nneg <= r_num[63];
    end

    // bring den below 2^31 by the least shift, binary steps 32..1
    logic [63:0] r_ndn [NORM_STEPS];
    logic [63:0] r_nmag [NORM_STEPS];
    logic        r_npol [NORM_STEPS];
    logic        r_nneg2 [NORM_STEPS];
    logic        r_nv [NORM_STEPS];

    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int SH = 32 >> j;
        logic [63:0] dn_in, mg_in;
        logic        pol_in, neg_in, v_in, cond;

        if (j == 0) begin : g_first
            assign dn_in = r_dn;
            assign mg_in = r_mag;
            assign pol_in = r_pol;
            assign neg_in = r_nneg;
            assign v_in = r_m5v;
        end else begin : g_next
            assign dn_in = r_ndn[j-1];
            assign mg_in = r_nmag[j-1];
            assign pol_in = r_npol[j-1];
            assign neg_in = r_nneg2[j-1];
            assign v_in = r_nv[j-1];
        end

        assign cond = (dn_in >> (30 + SH)) != 64'd0;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nv[j] <= 1'b0;
            end else begin
                r_nv[j] <= v_in;
            end
            r_ndn[j] <= cond ? dn_in >> SH : dn_in;
            r_nmag[j] <= cond ? mg_in >> SH : mg_in;
            r_npol[j] <= pol_in;
            r_nneg2[j] <= neg_in;
        end
    end

    // w = sqrt(den^2 - num^2) on the normalized pair
    logic [30:0] magc;
    logic [30:0] r_m6mag;
    logic [61:0] r_dsq, r_msq;
    logic        r_m6mz, r_m6pol, r_m6neg, r_m6v;
    logic [63:0] r_wv;
    logic [33:0] r_m7side;
    logic        r_m7v;

    assign magc = (r_nmag[NORM_STEPS-1] > r_ndn[NORM_STEPS-1]) ?
                  r_ndn[NORM_STEPS-1][30:0] : r_nmag[NORM_STEPS-1][30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m6v <= 1'b0;
            r_m7v <= 1'b0;
        end else begin
            r_m6v <= r_nv[NORM_STEPS-1];
            r_m7v <= r_m6v;
        end
        r_m6mag <= magc;
        r_dsq <= 62'(r_ndn[NORM_STEPS-1][30:0]) * 62'(r_ndn[NORM_STEPS-1][30:0]);
        r_msq <= 62'(magc) * 62'(magc);
        r_m6mz <= magc == 31'd0;
        r_m6pol <= r_npol[NORM_STEPS-1];
        r_m6neg <= r_nneg2[NORM_STEPS-1];
        r_wv <= 64'(r_dsq - r_msq);
        r_m7side <= {r_m6pol, r_m6neg, r_m6mz, r_m6mag};
    end

    logic [31:0] w_root;
    logic [33:0] w_side;
    logic        w_v;

    dayl_isqrt #(.SW(34)) u_w_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m7v),
        .i_v     (r_wv),
        .i_side  (r_m7side),
        .o_valid (w_v),
        .o_root  (w_root),
        .o_side  (w_side)
    );

    // hour angle by vectoring
    logic signed [CW-1:0] vec_z;
    logic [2:0]           vec_side;
    logic                 vec_v;

    dayl_cordic #(.STAGES(CORDIC_STAGES), .SW(3)) u_vec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vector_mode (1'b1),
        .i_valid       (w_v),
        .i_x           (signed'({2'b00, w_root})),
        .i_y           (signed'({3'b000, w_side[30:0]})),
        .i_z           ('0),
        .i_side        (w_side[33:31]),
        .o_valid       (vec_v),
        .o_x           (),
        .o_y           (),
        .o_z           (vec_z),
        .o_side        (vec_side)
    );

    // scale to 1/2048 hour and form the result
    logic [30:0] ang;
    logic [60:0] r_hp;
    logic        r_hpol, r_hneg, r_hv;
    logic [16:0] delta;
    logic [16:0] hsum;
    logic [15:0] hours;

    assign ang = (vec_side[0] || vec_z[CW-1]) ? 31'd0 : vec_z[30:0];
    assign delta = 17'((62'(r_hp) + (62'd1 << 45)) >> 46);
    assign hsum = 17'(HALF_DAY) + delta;

    always_comb begin
        if (r_hpol) begin
            hours = r_hneg ? 16'd0 : FULL_DAY;
        end else if (r_hneg) begin
            hours = (delta >= 17'(HALF_DAY)) ? 16'd0 : 16'(17'(HALF_DAY) - delta);
        end else begin
            hours = (hsum > 17'(FULL_DAY)) ? FULL_DAY : hsum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_hv <= vec_v;
            o_strobe <= r_hv;
        end
        r_hp <= 61'(ang) * 61'(HOUR_MUL);
        r_hpol <= vec_side[2];
        r_hneg <= vec_side[1];
        o_daylight_hours <= hours;
        o_polar_clamped <= r_hpol;
    end

    // ---------------- assertions ----------------
    `DAYL_ASSERT_IMP(a_strobe_from_start, i_clk, i_rst_n, o_strobe, $past(start && !busy, LATENCY), "result without a transfer at the pipeline latency")
    `DAYL_ASSERT_IMP(a_polar_full_or_none, i_clk, i_rst_n, o_strobe && o_polar_clamped, o_daylight_hours == 16'd0 || o_daylight_hours == FULL_DAY, "polar result not clamped to 0 or 24 hours")
    `DAYL_ASSERT_IMP(a_norm_in_range, i_clk, i_rst_n, r_nv[NORM_STEPS-1] && !r_npol[NORM_STEPS-1], r_ndn[NORM_STEPS-1] < 64'h8000_0000, "denominator not normalized below 2^31")
    `DAYL_ASSERT_NXT(a_strobe_follows_valid, i_clk, i_rst_n, r_hv, o_strobe, "final stage valid lost")

endmodule
